FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the echo delay block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a on one edge requires condition b on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle assertion failed");

// Condition a requires condition b on the same edge.
`define ASSERT_SAME(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle assertion failed");

`endif

FILE: sv/mted_pkg.sv
// Types and constants of the multi-tap echo delay block.
package mted_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // Configuration register indexes (word address bits).
  localparam logic [1:0] REG_DELAY = 2'd0;
  localparam logic [1:0] REG_ECHO  = 2'd1;
  localparam logic [1:0] REG_DRY   = 2'd2;

  // Register widths and reset values.
  localparam int DELAY_W = 14;
  localparam int ECHO_W  = 4;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 14'd4800;
  localparam logic [ECHO_W-1:0]  ECHO_RESET  = 4'd1;
  localparam logic               DRY_RESET   = 1'b1;

endpackage

FILE: sv/multi_tap_echo_delay_core.sv
// Multi-tap feed-forward echo delay: history ring memory, tap sequencer, APB registers.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_tvalid/in_tready | in_tdata: sample_in
//  out_    | output    | out_tvalid/tready   | out_tdata: sample_out, out_tuser: clipped
//  cfg_    | input     | APB, pready high    | delay_samples, echo_count, pass_dry
//
// Each item passes through the states in order: accept, then one read of the history
// memory per tap (echo_count after clamping) through its single read port, a flush
// to fold in the last read, and the write-back of the sample.
// After reset no clearing pass runs: a fill count marks how much of the ring
// holds samples, and taps that reach behind it read as zero.
// A result waits in the output register while the next item is accepted; the
// write-back stalls only while that register is full and out_tready is low.
`include "assert_macros.svh"

module multi_tap_echo_delay_core #(
  parameter int MAX_DELAY    = 8192,
  parameter int MAX_ECHOES   = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  // Output channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
  output logic [0:0]                          out_tuser,  // [0] clipped
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [3:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int RING    = MAX_DELAY * MAX_ECHOES;
  localparam int AW      = $clog2(RING);
  localparam int D_W     = $clog2(MAX_DELAY + 1);
  localparam int N_W     = $clog2(MAX_ECHOES + 1);
  localparam int ACC_W   = SAMPLE_WIDTH + $clog2(MAX_ECHOES + 2);
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  localparam logic [AW:0]      RING_W = (AW+1)'(RING);
  localparam logic [AW-1:0]    LAST_IDX = AW'(RING - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // Configuration registers.
  logic [mted_pkg::DELAY_W-1:0] delay_r;
  logic [mted_pkg::ECHO_W-1:0]  echo_r;
  logic                         dry_r;
  logic                         cfg_we;

  // Sequencer and datapath state.
  mted_pkg::state_t             state_r, state_nxt;
  logic [SAMPLE_WIDTH-1:0]      x_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic [D_W-1:0]               d_r;
  logic [AW:0]                  back_r;
  logic [N_W-1:0]               taps_left_r;
  logic [AW-1:0]                wr_idx_r;
  logic [AW:0]                  fill_r;
  logic                         rd_pend_r;
  logic                         rd_ok_r;
  logic [SAMPLE_WIDTH-1:0]      rd_data_r;

  // Output register.
  logic                         out_valid_r;
  logic [SAMPLE_WIDTH-1:0]      out_sample_r;
  logic                         out_clip_r;

  // History ring.
  logic [SAMPLE_WIDTH-1:0]      ring_mem [RING];

  // Control strobes and combinational values.
  logic                         in_acc;
  logic                         mem_re;
  logic                         mem_we;
  logic                         slot_free;
  logic [31:0]                  d_full;
  logic [31:0]                  n_full;
  logic [D_W-1:0]               d_clamp;
  logic [N_W-1:0]               n_clamp;
  logic [AW:0]                  wr_idx_w;
  logic [AW:0]                  idx_wide;
  logic [AW-1:0]                rd_addr;
  logic                         tap_ok;
  logic [AW+1:0]                back_sum;
  logic [AW:0]                  back_nxt;
  logic signed [ACC_W-1:0]      acc_fold;
  logic signed [ACC_W-1:0]      sat_val;
  logic                         sat_clip;

  // APB register file.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= mted_pkg::DELAY_RESET;
      echo_r  <= mted_pkg::ECHO_RESET;
      dry_r   <= mted_pkg::DRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_paddr[3:2])
        mted_pkg::REG_DELAY: delay_r <= cfg_pwdata[mted_pkg::DELAY_W-1:0];
        mted_pkg::REG_ECHO:  echo_r  <= cfg_pwdata[mted_pkg::ECHO_W-1:0];
        mted_pkg::REG_DRY:   dry_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      mted_pkg::REG_DELAY: cfg_prdata = 32'(delay_r);
      mted_pkg::REG_ECHO:  cfg_prdata = 32'(echo_r);
      mted_pkg::REG_DRY:   cfg_prdata = 32'(dry_r);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // Clamp delay and echo count to their legal ranges.
  always_comb begin
    d_full = 32'(delay_r);
    if (d_full == 32'd0) begin
      d_full = 32'd1;
    end else if (d_full > 32'(MAX_DELAY)) begin
      d_full = 32'(MAX_DELAY);
    end
    n_full = 32'(echo_r);
    if (n_full > 32'(MAX_ECHOES)) begin
      n_full = 32'(MAX_ECHOES);
    end
  end
  assign d_clamp = D_W'(d_full);
  assign n_clamp = N_W'(n_full);

  // Tap address: write index minus the tap distance, modulo the ring size.
  // A distance of a full ring points at the slot about to be overwritten.
  assign wr_idx_w = {1'b0, wr_idx_r};
  assign idx_wide = (wr_idx_w >= back_r) ? (wr_idx_w - back_r)
                                         : (wr_idx_w + RING_W - back_r);
  assign rd_addr  = idx_wide[AW-1:0];
  assign tap_ok   = (fill_r >= back_r);

  // Next tap distance wraps at the ring size.
  assign back_sum = {1'b0, back_r} + (AW+2)'(d_r);
  assign back_nxt = (back_sum > {1'b0, RING_W}) ? (AW+1)'(back_sum - {1'b0, RING_W})
                                                : back_sum[AW:0];

  // Add the tap read in the previous cycle, or zero if it reached behind the fill.
  assign acc_fold = (rd_pend_r && rd_ok_r)
                  ? acc_r + ACC_W'($signed(rd_data_r))
                  : acc_r;

  // Saturate the finished sum.
  always_comb begin
    sat_val  = acc_r;
    sat_clip = 1'b0;
    if (acc_r > SAT_MAX) begin
      sat_val  = SAT_MAX;
      sat_clip = 1'b1;
    end else if (acc_r < SAT_MIN) begin
      sat_val  = SAT_MIN;
      sat_clip = 1'b1;
    end
  end

  // Sequencer next state and strobes.
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    in_acc    = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      mted_pkg::ST_IDLE: begin
        in_acc = in_tvalid;
        if (in_tvalid) begin
          state_nxt = (n_clamp == '0) ? mted_pkg::ST_FLUSH : mted_pkg::ST_READ;
        end
      end
      mted_pkg::ST_READ: begin
        mem_re = 1'b1;
        if (taps_left_r == N_W'(1)) begin
          state_nxt = mted_pkg::ST_FLUSH;
        end
      end
      mted_pkg::ST_FLUSH: begin
        state_nxt = mted_pkg::ST_DONE;
      end
      mted_pkg::ST_DONE: begin
        if (slot_free) begin
          mem_we    = 1'b1;
          state_nxt = mted_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mted_pkg::ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == mted_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mted_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state: write index, fill count, read tracking, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      taps_left_r <= '0;
    end else begin
      if (in_acc) begin
        taps_left_r <= n_clamp;
      end else if (mem_re) begin
        taps_left_r <= taps_left_r - N_W'(1);
      end
      if (mem_re) begin
        rd_pend_r <= 1'b1;
        rd_ok_r   <= tap_ok;
      end else if (state_r == mted_pkg::ST_FLUSH) begin
        rd_pend_r <= 1'b0;
      end
      if (mem_we) begin
        wr_idx_r <= (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + AW'(1);
        if (fill_r != RING_W) begin
          fill_r <= fill_r + (AW+1)'(1);
        end
      end
      if (mem_we) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= in_tdata[SAMPLE_WIDTH-1:0];
      acc_r  <= dry_r ? ACC_W'($signed(in_tdata[SAMPLE_WIDTH-1:0])) : '0;
      d_r    <= d_clamp;
      back_r <= (AW+1)'(d_clamp);
    end else if (mem_re || state_r == mted_pkg::ST_FLUSH) begin
      acc_r <= acc_fold;
      if (mem_re) begin
        back_r <= back_nxt;
      end
    end
    if (mem_we) begin
      out_sample_r <= sat_val[SAMPLE_WIDTH-1:0];
      out_clip_r   <= sat_clip;
    end
  end

  // History ring memory: one read port, one write port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_idx_r] <= x_r;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // Output channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_sample_r);
  assign out_tuser  = out_clip_r;

  // An accepted item always starts the sequencer.
  `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready,
               state_r != mted_pkg::ST_IDLE)
  // The write-back always presents a result.
  `ASSERT_NEXT(a_write_gives_result, clk, rst_n, mem_we, out_valid_r)
  // With the output register free, the write-back never stalls.
  `ASSERT_NEXT(a_done_no_stall, clk, rst_n,
               state_r == mted_pkg::ST_DONE && !out_valid_r,
               state_r == mted_pkg::ST_IDLE)

endmodule
